// ===== design/srs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package srs_pkg;

  // table sizes and fixed widths
  localparam int unsigned NUM_REACTIONS = 16;
  localparam int unsigned NUM_SPECIES   = 16;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned CNT_W         = 32;

  // request codes
  localparam logic [1:0] REQ_REACTION = 2'd0;
  localparam logic [1:0] REQ_SPECIES  = 2'd1;
  localparam logic [1:0] REQ_STEP     = 2'd2;

  // ln(2) as a 32-bit fraction
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  // count change for a consumed reactant
  localparam logic signed [7:0] DELTA_DEC = -8'sd1;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NOP    = 5'd0,
    OP_START  = 5'd1,
    OP_LOAD   = 5'd2,
    OP_RD_X   = 5'd3,
    OP_RD_Y   = 5'd4,
    OP_MUL_KX = 5'd5,
    OP_MUL_LO = 5'd6,
    OP_MUL_HI = 5'd7,
    OP_ACC    = 5'd8,
    OP_CHK    = 5'd9,
    OP_NORM   = 5'd10,
    OP_SQ     = 5'd11,
    OP_LN_LO  = 5'd12,
    OP_LN_HI  = 5'd13,
    OP_DINIT  = 5'd14,
    OP_DIV    = 5'd15,
    OP_TGT_LO = 5'd16,
    OP_TGT_HI = 5'd17,
    OP_WINIT  = 5'd18,
    OP_WALK   = 5'd19,
    OP_UPD    = 5'd20,
    OP_OUT    = 5'd21
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_step;
    logic active_zero;
    logic last_reaction;
    logic total_zero;
    logic u1_zero;
    logic x_msb;
    logic sq_last;
    logic div_last;
    logic walk_go;
    logic upd_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/srs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module srs_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire              out_stall,
  input  srs_pkg::sts_t    sts,
  output srs_pkg::cmd_t    cmd
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_PROP_X = 20'h00002,
    S_PROP_Y = 20'h00004,
    S_MUL_KX = 20'h00008,
    S_MUL_LO = 20'h00010,
    S_MUL_HI = 20'h00020,
    S_ACC    = 20'h00040,
    S_CHK    = 20'h00080,
    S_NORM   = 20'h00100,
    S_SQ     = 20'h00200,
    S_LN_LO  = 20'h00400,
    S_LN_HI  = 20'h00800,
    S_DINIT  = 20'h01000,
    S_DIV    = 20'h02000,
    S_TGT_LO = 20'h04000,
    S_TGT_HI = 20'h08000,
    S_WINIT  = 20'h10000,
    S_WALK   = 20'h20000,
    S_UPD    = 20'h40000,
    S_DONE   = 20'h80000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // next state and command
  always_comb begin
    state_next = state;
    cmd.op     = srs_pkg::OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_step) begin
            cmd.op     = srs_pkg::OP_START;
            state_next = sts.active_zero ? S_CHK : S_PROP_X;
          end else begin
            cmd.op     = srs_pkg::OP_LOAD;
            state_next = S_DONE;
          end
        end
      end
      S_PROP_X: begin
        cmd.op = srs_pkg::OP_RD_X; state_next = S_PROP_Y;
      end
      S_PROP_Y: begin
        cmd.op = srs_pkg::OP_RD_Y; state_next = S_MUL_KX;
      end
      S_MUL_KX: begin
        cmd.op = srs_pkg::OP_MUL_KX; state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op = srs_pkg::OP_MUL_LO; state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.op = srs_pkg::OP_MUL_HI; state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = srs_pkg::OP_ACC;
        state_next = sts.last_reaction ? S_CHK : S_PROP_X;
      end
      S_CHK: begin
        cmd.op = srs_pkg::OP_CHK;
        if (sts.total_zero) state_next = S_DONE;
        else if (sts.u1_zero) state_next = S_TGT_LO;
        else state_next = S_NORM;
      end
      S_NORM: begin
        cmd.op = srs_pkg::OP_NORM;
        if (sts.x_msb) state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op = srs_pkg::OP_SQ;
        if (sts.sq_last) state_next = S_LN_LO;
      end
      S_LN_LO: begin
        cmd.op = srs_pkg::OP_LN_LO; state_next = S_LN_HI;
      end
      S_LN_HI: begin
        cmd.op = srs_pkg::OP_LN_HI; state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.op = srs_pkg::OP_DINIT; state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = srs_pkg::OP_DIV;
        if (sts.div_last) state_next = S_TGT_LO;
      end
      S_TGT_LO: begin
        cmd.op = srs_pkg::OP_TGT_LO; state_next = S_TGT_HI;
      end
      S_TGT_HI: begin
        cmd.op = srs_pkg::OP_TGT_HI; state_next = S_WINIT;
      end
      S_WINIT: begin
        cmd.op = srs_pkg::OP_WINIT; state_next = S_WALK;
      end
      S_WALK: begin
        cmd.op = srs_pkg::OP_WALK;
        if (!sts.walk_go) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op = srs_pkg::OP_UPD;
        if (sts.upd_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op     = srs_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == srs_pkg::OP_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== design/srs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module srs_dp (
  input  wire                clk,
  input  wire                rst,
  input  srs_pkg::cmd_t      cmd,
  output srs_pkg::sts_t      sts,
  input  wire                cfg_we,
  input  wire  [4:0]         cfg_data,
  input  wire  [1:0]         req_type,
  input  wire  [3:0]         entry_index,
  input  wire  [31:0]        data_value,
  input  wire  [1:0]         reactant_count,
  input  wire  [3:0]         reactant_first,
  input  wire  [3:0]         reactant_second,
  input  wire  [1:0]         product_count,
  input  wire  [3:0]         product_first,
  input  wire  signed [7:0]  product_first_change,
  input  wire  [3:0]         product_second,
  input  wire  signed [7:0]  product_second_change,
  input  wire  [63:0]        random_bits,
  output logic [3:0]         chosen_reaction,
  output logic [63:0]        time_step,
  output logic               no_reaction_possible,
  output logic [63:0]        propensity_total
);

  localparam int unsigned NR = srs_pkg::NUM_REACTIONS;
  localparam int unsigned NS = srs_pkg::NUM_SPECIES;
  localparam int unsigned IW = srs_pkg::IDX_W;
  localparam int unsigned CW = srs_pkg::CNT_W;

  // reaction tables
  logic [31:0]          rate_tab [NR];
  logic [1:0]           rc_tab   [NR];
  logic [IW-1:0]        ra_tab   [NR];
  logic [IW-1:0]        rb_tab   [NR];
  logic [1:0]           pc_tab   [NR];
  logic [IW-1:0]        p1_tab   [NR];
  logic signed [7:0]    c1_tab   [NR];
  logic [IW-1:0]        p2_tab   [NR];
  logic signed [7:0]    c2_tab   [NR];
  logic [63:0]          scratch  [NR];
  logic [CW-1:0]        counts   [NS];

  logic [4:0]   active;
  logic [4:0]   n_eff;
  logic [IW-1:0] i;
  logic [5:0]   it;
  logic [63:0]  rnd;
  logic [31:0]  k, px, py;
  logic [63:0]  prod, plo, phi;
  logic [63:0]  total, acc, cumu, quo, rem;
  logic [31:0]  lx, f;
  logic [4:0]   z;
  logic [3:0]   res_chosen;
  logic [63:0]  res_time, res_total;
  logic         res_none;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [37:0]  l_val;
  logic [64:0]  prop_sum, tot_sum, cumu_sum, rem_sh;
  logic [63:0]  prop_sat, scr_rd;
  logic         div_ge;
  logic [IW-1:0] scr_addr;
  logic [CW-1:0] cnt_a, cnt_b;
  logic [32:0]  sq_sh;
  logic         upd_en;
  logic [IW-1:0] upd_idx;
  logic signed [7:0]  upd_d;
  logic signed [33:0] adj_sum;
  logic [CW-1:0] adj_val;
  logic [1:0]   rc_in, pc_in;

  assign n_eff = (active > 5'(NR)) ? 5'(NR) : active;
  assign cnt_a = counts[ra_tab[i]];
  assign cnt_b = counts[rb_tab[i]];
  assign l_val = {{1'b0, z} + 6'd1, 32'd0} - {6'd0, f};
  assign rc_in = (reactant_count == 2'd3) ? 2'd2 : reactant_count;
  assign pc_in = (product_count == 2'd3) ? 2'd2 : product_count;

  // shared multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (cmd.op)
      srs_pkg::OP_MUL_KX: begin mul_a = k;           mul_b = px; end
      srs_pkg::OP_MUL_LO: begin mul_a = prod[31:0];  mul_b = py; end
      srs_pkg::OP_MUL_HI: begin mul_a = prod[63:32]; mul_b = py; end
      srs_pkg::OP_SQ:     begin mul_a = lx;          mul_b = lx; end
      srs_pkg::OP_LN_LO:  begin mul_a = l_val[31:0]; mul_b = srs_pkg::LN2_Q32; end
      srs_pkg::OP_LN_HI:  begin
        mul_a = {26'd0, l_val[37:32]};
        mul_b = srs_pkg::LN2_Q32;
      end
      srs_pkg::OP_TGT_LO: begin mul_a = rnd[31:0];   mul_b = total[31:0]; end
      srs_pkg::OP_TGT_HI: begin mul_a = rnd[31:0];   mul_b = total[63:32]; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // saturating propensity and sums
  assign prop_sum = {1'b0, phi[31:0], 32'd0} + {1'b0, plo};
  assign prop_sat = ((|phi[63:32]) || prop_sum[64]) ? '1 : prop_sum[63:0];
  assign tot_sum  = {1'b0, total} + {1'b0, prop_sat};
  assign scr_addr = (cmd.op == srs_pkg::OP_WINIT) ? '0 : i + 1'b1;
  assign scr_rd   = scratch[scr_addr];
  assign cumu_sum = {1'b0, cumu} + {1'b0, scr_rd};

  // squaring round and divider step
  assign sq_sh  = mul_p[63:31];
  assign rem_sh = {rem, quo[63]};
  assign div_ge = rem_sh >= {1'b0, total};

  // count update select
  always_comb begin
    upd_en  = 1'b0;
    upd_idx = ra_tab[i];
    upd_d   = srs_pkg::DELTA_DEC;
    unique case (it[1:0])
      2'd0: begin upd_en = (rc_tab[i] >= 2'd1); upd_idx = ra_tab[i]; end
      2'd1: begin upd_en = (rc_tab[i] >= 2'd2); upd_idx = rb_tab[i]; end
      2'd2: begin
        upd_en = (pc_tab[i] >= 2'd1); upd_idx = p1_tab[i]; upd_d = c1_tab[i];
      end
      2'd3: begin
        upd_en = (pc_tab[i] >= 2'd2); upd_idx = p2_tab[i]; upd_d = c2_tab[i];
      end
      default: upd_en = 1'b0;
    endcase
  end
  assign adj_sum = $signed({2'b00, counts[upd_idx]}) + 34'(upd_d);
  assign adj_val = adj_sum[33] ? '0 : (adj_sum[32] ? '1 : adj_sum[31:0]);

  // status to controller
  assign sts.is_step       = (req_type == srs_pkg::REQ_STEP);
  assign sts.active_zero   = (active == 5'd0);
  assign sts.last_reaction = ({1'b0, i} + 5'd1 == n_eff);
  assign sts.total_zero    = (total == 64'd0);
  assign sts.u1_zero       = (rnd[63:32] == 32'd0);
  assign sts.x_msb         = lx[31];
  assign sts.sq_last       = (it[4:0] == 5'd31);
  assign sts.div_last      = (it == 6'd63);
  assign sts.walk_go       = (cumu <= acc) && ({1'b0, i} + 5'd1 < n_eff);
  assign sts.upd_last      = (it[1:0] == 2'd3);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 5'd16;
    end else if (cfg_we) begin
      active <= cfg_data;
    end
  end

  // species counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) counts[s] <= '0;
    end else begin
      if (cmd.op == srs_pkg::OP_LOAD && req_type == srs_pkg::REQ_SPECIES) begin
        counts[entry_index] <= data_value;
      end else if (cmd.op == srs_pkg::OP_UPD && upd_en) begin
        counts[upd_idx] <= adj_val;
      end
    end
  end

  // reaction tables
  always_ff @(posedge clk) begin
    if (cmd.op == srs_pkg::OP_LOAD && req_type == srs_pkg::REQ_REACTION) begin
      rate_tab[entry_index] <= data_value;
      rc_tab[entry_index]   <= rc_in;
      ra_tab[entry_index]   <= reactant_first;
      rb_tab[entry_index]   <= reactant_second;
      pc_tab[entry_index]   <= pc_in;
      p1_tab[entry_index]   <= product_first;
      c1_tab[entry_index]   <= product_first_change;
      p2_tab[entry_index]   <= product_second;
      c2_tab[entry_index]   <= product_second_change;
    end
    if (cmd.op == srs_pkg::OP_ACC) scratch[i] <= prop_sat;
  end

  // step datapath
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      srs_pkg::OP_LOAD: begin
        res_chosen <= '0;
        res_time   <= '0;
        res_none   <= 1'b0;
        res_total  <= '0;
      end
      srs_pkg::OP_START: begin
        i     <= '0;
        total <= '0;
        rnd   <= random_bits;
      end
      srs_pkg::OP_RD_X: begin
        k  <= rate_tab[i];
        px <= (rc_tab[i] != 2'd0) ? cnt_a : 32'd1;
      end
      srs_pkg::OP_RD_Y: begin
        if (rc_tab[i] < 2'd2) py <= 32'd1;
        else if (ra_tab[i] == rb_tab[i]) py <= (px == 32'd0) ? 32'd0 : px - 32'd1;
        else py <= cnt_b;
      end
      srs_pkg::OP_MUL_KX: prod <= mul_p;
      srs_pkg::OP_MUL_LO: plo  <= mul_p;
      srs_pkg::OP_MUL_HI: phi  <= mul_p;
      srs_pkg::OP_ACC: begin
        total <= tot_sum[64] ? '1 : tot_sum[63:0];
        i     <= i + 1'b1;
      end
      srs_pkg::OP_CHK: begin
        res_chosen <= '0;
        res_none   <= (total == 64'd0);
        res_total  <= total;
        res_time   <= ((total != 64'd0) && (rnd[63:32] == 32'd0)) ? '1 : '0;
        lx         <= rnd[63:32];
        z          <= '0;
        f          <= '0;
      end
      srs_pkg::OP_NORM: begin
        if (!lx[31]) begin
          lx <= {lx[30:0], 1'b0};
          z  <= z + 5'd1;
        end
        it <= '0;
      end
      srs_pkg::OP_SQ: begin
        if (sq_sh[32]) begin
          lx           <= sq_sh[32:1];
          f[~it[4:0]]  <= 1'b1;
        end else begin
          lx <= sq_sh[31:0];
        end
        it <= it + 6'd1;
      end
      srs_pkg::OP_LN_LO: acc <= {32'd0, mul_p[63:32]};
      srs_pkg::OP_LN_HI: acc <= acc + mul_p;
      srs_pkg::OP_DINIT: begin
        quo <= {acc[39:0], 24'd0};
        rem <= '0;
        it  <= '0;
      end
      srs_pkg::OP_DIV: begin
        rem <= div_ge ? 64'(rem_sh - {1'b0, total}) : rem_sh[63:0];
        quo <= {quo[62:0], div_ge};
        it  <= it + 6'd1;
        if (it == 6'd63) res_time <= {quo[62:0], div_ge};
      end
      srs_pkg::OP_TGT_LO: acc <= {32'd0, mul_p[63:32]};
      srs_pkg::OP_TGT_HI: acc <= acc + mul_p;
      srs_pkg::OP_WINIT: begin
        i    <= '0;
        cumu <= scr_rd;
      end
      srs_pkg::OP_WALK: begin
        if (sts.walk_go) begin
          i    <= i + 1'b1;
          cumu <= cumu_sum[64] ? '1 : cumu_sum[63:0];
        end else begin
          res_chosen <= i;
          it         <= '0;
        end
      end
      srs_pkg::OP_UPD: it <= it + 6'd1;
      srs_pkg::OP_OUT: begin
        chosen_reaction      <= res_chosen;
        time_step            <= res_time;
        no_reaction_possible <= res_none;
        propensity_total     <= res_total;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/stochastic_reaction_step_top.sv =====
// sequence: a load writes its table entry, then its result is registered at the
// output; a step reads, multiplies and sums each active reaction, checks the sum
// (a zero sum goes to output), takes the log and divides (skipped on a zero upper
// random word), sets the target, walks, updates counts and registers the output
// throughput: one item at a time, set by the shared 32x32 multiplier and the
// bit-serial divider; a new item is taken while the last result waits
// reset: synchronous, clears control state and species counts, active count 16
`timescale 1ns / 1ps
`default_nettype none
module stochastic_reaction_step_top (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [4:0]         cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [1:0]         req_type,
  input  wire  [3:0]         entry_index,
  input  wire  [31:0]        data_value,
  input  wire  [1:0]         reactant_count,
  input  wire  [3:0]         reactant_first,
  input  wire  [3:0]         reactant_second,
  input  wire  [1:0]         product_count,
  input  wire  [3:0]         product_first,
  input  wire  signed [7:0]  product_first_change,
  input  wire  [3:0]         product_second,
  input  wire  signed [7:0]  product_second_change,
  input  wire  [63:0]        random_bits,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [3:0]         chosen_reaction,
  output logic [63:0]        time_step,
  output logic               no_reaction_possible,
  output logic [63:0]        propensity_total
);

  srs_pkg::cmd_t cmd;
  srs_pkg::sts_t sts;

  // config writes are to be issued only while idle; the block itself does not enforce it
  assign cfg_ready = 1'b1;

  // sequencer
  srs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tables, arithmetic and result register
  srs_dp u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_valid),
    .cfg_data              (cfg_data),
    .req_type              (req_type),
    .entry_index           (entry_index),
    .data_value            (data_value),
    .reactant_count        (reactant_count),
    .reactant_first        (reactant_first),
    .reactant_second       (reactant_second),
    .product_count         (product_count),
    .product_first         (product_first),
    .product_first_change  (product_first_change),
    .product_second        (product_second),
    .product_second_change (product_second_change),
    .random_bits           (random_bits),
    .chosen_reaction       (chosen_reaction),
    .time_step             (time_step),
    .no_reaction_possible  (no_reaction_possible),
    .propensity_total      (propensity_total)
  );

endmodule
`default_nettype wire
